// ===== rtl/multi_frame_3d_convolution_macros.svh =====
// Assertion shorthands for the top-level file, which checks itself.
`ifndef MULTI_FRAME_3D_CONVOLUTION_MACROS_SVH
`define MULTI_FRAME_3D_CONVOLUTION_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MFC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define MFC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/mfc_pkg.sv =====
package mfc_pkg;

	// Default sizes of the stores.
	localparam int DEF_MAX_WIDTH       = 64;
	localparam int DEF_MAX_HEIGHT      = 64;
	localparam int DEF_MAX_FRAMES      = 4;
	localparam int DEF_MAX_KERNEL_SIDE = 7;

	// Samples per pixel, fixed by the three result fields.
	localparam int CHANNELS = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_DEPTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd5;

	localparam logic [6:0] RST_IMAGE_WIDTH   = 7'd64;
	localparam logic [6:0] RST_IMAGE_HEIGHT  = 7'd64;
	localparam logic [2:0] RST_KERNEL_WIDTH  = 3'd3;
	localparam logic [2:0] RST_KERNEL_HEIGHT = 3'd3;
	localparam logic [2:0] RST_KERNEL_DEPTH  = 3'd1;
	localparam logic [1:0] RST_CHANNEL_COUNT = 2'd3;

	// Item operations.
	localparam logic [1:0] OP_COEF    = 2'd0;
	localparam logic [1:0] OP_PIXEL   = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// Fixed-point rounding of the Q.12 sums.
	localparam int FRAC_BITS = 12;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WALK,
		SEQ_DRAIN,
		SEQ_FINISH
	} seq_state_t;

	// Sequencer commands to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctrl_t;

	typedef logic [CHANNELS-1:0][7:0] lane_bytes_t;

	// Bits needed to index n entries.
	function automatic int idx_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Bits needed to hold the value n itself.
	function automatic int cnt_bits(input int n);
		return $clog2(n + 1);
	endfunction

	// Width for position arithmetic: image sizes, row/col ports and the pad.
	function automatic int coord_bits(input int w, input int h);
		int m;
		m = (cnt_bits(w) > cnt_bits(h)) ? cnt_bits(w) : cnt_bits(h);
		return ((m > 7) ? m : 7) + 1;
	endfunction

endpackage

// ===== rtl/mfc_ram.sv =====
module mfc_ram
	import mfc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = idx_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mfc_mac.sv =====
module mfc_mac
	import mfc_pkg::*;
#(
	parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
	parameter int MAX_KERNEL_SIDE = DEF_MAX_KERNEL_SIDE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctrl_t          ctrl,
	input  lane_bytes_t        pix,
	input  logic signed [15:0] coef,
	input  logic [1:0]         cs,
	output logic               pending,
	output lane_bytes_t        result
);

	localparam int PW = 25;
	localparam int AW = PW + cnt_bits(MAX_FRAMES * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE);

	logic                 take_s1;
	logic                 valid_s2;
	logic signed [PW-1:0] prod_s2 [CHANNELS];
	logic signed [AW-1:0] acc_q   [CHANNELS];
	logic        [AW-1:0] rsum    [CHANNELS];

	// Store data arrives in the cycle after the sequencer issues the tap address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			take_s1  <= ctrl.issue;
			valid_s2 <= take_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < CHANNELS; l++) begin
			if (take_s1) begin
				prod_s2[l] <= $signed({1'b0, pix[l]}) * coef;
			end
			if (ctrl.clear) begin
				acc_q[l] <= '0;
			end else if (valid_s2) begin
				acc_q[l] <= acc_q[l] + AW'(prod_s2[l]);
			end
		end
	end

	assign pending = take_s1 | valid_s2;

	// Round half up to an integer, then clamp to the byte range; lanes at or above the channel count give zero.
	always_comb begin
		for (int l = 0; l < CHANNELS; l++) begin
			rsum[l] = AW'(acc_q[l]) + AW'(1 << (FRAC_BITS - 1));
			if (acc_q[l][AW-1] || (int'(cs) <= l)) begin
				result[l] = 8'd0;
			end else if (|rsum[l][AW-1:FRAC_BITS+8]) begin
				result[l] = 8'hFF;
			end else begin
				result[l] = rsum[l][FRAC_BITS+7:FRAC_BITS];
			end
		end
	end

endmodule

// ===== rtl/mfc_seq.sv =====
module mfc_seq
	import mfc_pkg::*;
#(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
	parameter int MAX_KERNEL_SIDE = DEF_MAX_KERNEL_SIDE,
	localparam int FW  = idx_bits(MAX_FRAMES),
	localparam int YW  = idx_bits(MAX_HEIGHT),
	localparam int XW  = idx_bits(MAX_WIDTH),
	localparam int KSW = cnt_bits(MAX_KERNEL_SIDE),
	localparam int KDW = cnt_bits(MAX_FRAMES),
	localparam int DW  = coord_bits(MAX_WIDTH, MAX_HEIGHT),
	localparam int PAW = FW + YW + XW,
	localparam int CAW = FW + 2 * KSW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           interior,
	input  logic [DW-1:0]  base_y,
	input  logic [DW-1:0]  base_x,
	input  logic [KSW-1:0] kw,
	input  logic [KSW-1:0] kh,
	input  logic [KDW-1:0] kd,
	input  logic           mac_pending,
	input  logic           out_free,
	output logic           busy,
	output mac_ctrl_t      mac_ctrl,
	output logic [CAW-1:0] coef_addr,
	output logic [PAW-1:0] pix_addr,
	output logic           load,
	output logic           pos_valid
);

	seq_state_t     state_q, state_d;
	logic [KSW-1:0] dx_q, dy_q;
	logic [FW-1:0]  dz_q;
	logic [DW-1:0]  base_y_q, base_x_q;
	logic           pos_valid_q;
	logic           dx_last, dy_last, dz_last, tap_last;

	assign dx_last  = (dx_q == kw - KSW'(1));
	assign dy_last  = (dy_q == kh - KSW'(1));
	assign dz_last  = (KDW'(dz_q) == kd - KDW'(1));
	assign tap_last = dx_last && dy_last && dz_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tap counters: column fastest, then row, then frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q        <= '0;
			dy_q        <= '0;
			dz_q        <= '0;
			pos_valid_q <= 1'b0;
		end else if (start) begin
			dx_q        <= '0;
			dy_q        <= '0;
			dz_q        <= '0;
			pos_valid_q <= interior;
		end else if (state_q == SEQ_WALK) begin
			if (dx_last) begin
				dx_q <= '0;
				if (dy_last) begin
					dy_q <= '0;
					dz_q <= dz_q + FW'(1);
				end else begin
					dy_q <= dy_q + KSW'(1);
				end
			end else begin
				dx_q <= dx_q + KSW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_y_q <= base_y;
			base_x_q <= base_x;
		end
	end

	assign coef_addr = {dz_q, dy_q, dx_q};
	assign pix_addr  = {dz_q, YW'(base_y_q + DW'(dy_q)), XW'(base_x_q + DW'(dx_q))};
	assign pos_valid = pos_valid_q;
	assign busy      = (state_q != SEQ_IDLE);

	always_comb begin
		state_d        = state_q;
		mac_ctrl.clear = 1'b0;
		mac_ctrl.issue = 1'b0;
		load           = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					mac_ctrl.clear = 1'b1;
					state_d        = interior ? SEQ_WALK : SEQ_FINISH;
				end
			end
			SEQ_WALK: begin
				mac_ctrl.issue = 1'b1;
				if (tap_last) begin
					state_d = SEQ_DRAIN;
				end
			end
			SEQ_DRAIN: begin
				if (!mac_pending) begin
					state_d = SEQ_FINISH;
				end
			end
			SEQ_FINISH: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/multi_frame_3d_convolution.sv =====
// Multi-frame 3D convolution over a stack of stored frames.
// Input channel (in_valid / in_stall): one beat is one item. Coefficient and
// pixel-sample writes go straight into their stores and give no result. A
// compute beat walks frames 0..kd-1 of the kernel window, one tap a cycle
// through a single three-lane multiply-accumulate unit, and gives exactly
// one result. A border position skips the walk and returns zeros with
// position_valid low. in_stall stays high from a compute beat until its
// result has been loaded into the output register, so no further item is
// taken while a compute beat is in progress. Write beats can be taken every
// cycle while no compute beat holds the input.
// Output channel (out_valid / out_stall): the result sits in an output
// register until taken; while the receiver stalls, the sequencer holds the
// finished sums and further items wait.
// Configuration writes (config_write) apply at once; the user must make them
// while idle, which the block itself does not enforce.
// Reset clears control state and sets the registers to a 64x64 image, a
// 3x3x1 kernel and three channels; the stores hold nothing until written.
`include "multi_frame_3d_convolution_macros.svh"

module multi_frame_3d_convolution
	import mfc_pkg::*;
#(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
	parameter int MAX_KERNEL_SIDE = DEF_MAX_KERNEL_SIDE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  config_write,
	input  logic [CFG_IDX_W-1:0]  config_index,
	input  logic [CFG_DATA_W-1:0] config_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [1:0]            frame,
	input  logic [5:0]            row,
	input  logic [5:0]            col,
	input  logic [1:0]            channel,
	input  logic [7:0]            sample,
	input  logic signed [15:0]    coefficient,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  position_valid,
	output logic [7:0]            result_ch0,
	output logic [7:0]            result_ch1,
	output logic [7:0]            result_ch2
);

	localparam int FW  = idx_bits(MAX_FRAMES);
	localparam int YW  = idx_bits(MAX_HEIGHT);
	localparam int XW  = idx_bits(MAX_WIDTH);
	localparam int KSW = cnt_bits(MAX_KERNEL_SIDE);
	localparam int KDW = cnt_bits(MAX_FRAMES);
	localparam int DW  = coord_bits(MAX_WIDTH, MAX_HEIGHT);
	localparam int PAW = FW + YW + XW;
	localparam int CAW = FW + 2 * KSW;

	logic [6:0] image_width_q, image_height_q;
	logic [2:0] kernel_width_q, kernel_height_q, kernel_depth_q;
	logic [1:0] channel_count_q;

	logic [DW-1:0]  w_sat, h_sat, pad_w, pad_h, row_e, col_e;
	logic [KSW-1:0] kw_sat, kh_sat;
	logic [KDW-1:0] kd_sat;
	logic [1:0]     cs_sat;
	logic           interior;

	logic           in_accept, start;
	logic           coef_we;
	logic [CAW-1:0] coef_waddr;
	logic [PAW-1:0] pix_waddr;
	logic           pix_ok;

	logic           seq_busy, load, seq_pos_valid, mac_pending, out_free;
	mac_ctrl_t      mac_ctrl;
	logic [CAW-1:0] coef_raddr;
	logic [PAW-1:0] pix_raddr;
	logic [15:0]    coef_rdata;
	lane_bytes_t    pix_rdata;
	lane_bytes_t    mac_result;

	logic           out_valid_q, position_valid_q;
	lane_bytes_t    result_q;
	logic           results_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= RST_IMAGE_WIDTH;
			image_height_q  <= RST_IMAGE_HEIGHT;
			kernel_width_q  <= RST_KERNEL_WIDTH;
			kernel_height_q <= RST_KERNEL_HEIGHT;
			kernel_depth_q  <= RST_KERNEL_DEPTH;
			channel_count_q <= RST_CHANNEL_COUNT;
		end else if (config_write) begin
			unique case (config_index)
				CFG_IMAGE_WIDTH:   image_width_q   <= config_data;
				CFG_IMAGE_HEIGHT:  image_height_q  <= config_data;
				CFG_KERNEL_WIDTH:  kernel_width_q  <= config_data[2:0];
				CFG_KERNEL_HEIGHT: kernel_height_q <= config_data[2:0];
				CFG_KERNEL_DEPTH:  kernel_depth_q  <= config_data[2:0];
				CFG_CHANNEL_COUNT: channel_count_q <= config_data[1:0];
				default: ;
			endcase
		end
	end

	// Registers out of range act as the nearest value in range; zero acts as one.
	always_comb begin
		if (image_width_q == '0) begin
			w_sat = DW'(1);
		end else if (DW'(image_width_q) > DW'(MAX_WIDTH)) begin
			w_sat = DW'(MAX_WIDTH);
		end else begin
			w_sat = DW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_sat = DW'(1);
		end else if (DW'(image_height_q) > DW'(MAX_HEIGHT)) begin
			h_sat = DW'(MAX_HEIGHT);
		end else begin
			h_sat = DW'(image_height_q);
		end
		if (kernel_width_q == '0) begin
			kw_sat = KSW'(1);
		end else if (5'(kernel_width_q) > 5'(MAX_KERNEL_SIDE)) begin
			kw_sat = KSW'(MAX_KERNEL_SIDE);
		end else begin
			kw_sat = KSW'(kernel_width_q);
		end
		if (kernel_height_q == '0) begin
			kh_sat = KSW'(1);
		end else if (5'(kernel_height_q) > 5'(MAX_KERNEL_SIDE)) begin
			kh_sat = KSW'(MAX_KERNEL_SIDE);
		end else begin
			kh_sat = KSW'(kernel_height_q);
		end
		if (kernel_depth_q == '0) begin
			kd_sat = KDW'(1);
		end else if (5'(kernel_depth_q) > 5'(MAX_FRAMES)) begin
			kd_sat = KDW'(MAX_FRAMES);
		end else begin
			kd_sat = KDW'(kernel_depth_q);
		end
		cs_sat = (channel_count_q == '0) ? 2'd1 : channel_count_q;
	end

	assign pad_w = DW'(kw_sat >> 1);
	assign pad_h = DW'(kh_sat >> 1);
	assign row_e = DW'(row);
	assign col_e = DW'(col);

	// A kernel larger than the image leaves no interior at all.
	assign interior = (row_e >= pad_h) && (row_e + pad_h < h_sat) &&
		(col_e >= pad_w) && (col_e + pad_w < w_sat);

	assign in_stall  = seq_busy;
	assign in_accept = in_valid && !in_stall;
	assign start     = in_accept && (op == OP_COMPUTE);

	assign coef_we = in_accept && (op == OP_COEF) && (int'(frame) < MAX_FRAMES) &&
		(int'(row) < MAX_KERNEL_SIDE) && (int'(col) < MAX_KERNEL_SIDE);
	assign coef_waddr = {FW'(frame), KSW'(row), KSW'(col)};

	assign pix_ok = in_accept && (op == OP_PIXEL) && (int'(frame) < MAX_FRAMES) &&
		(int'(row) < MAX_HEIGHT) && (int'(col) < MAX_WIDTH);
	assign pix_waddr = {FW'(frame), YW'(row), XW'(col)};

	mfc_ram #(
		.WIDTH (16),
		.DEPTH (1 << CAW)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coefficient),
		.re    (mac_ctrl.issue),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	// One store per channel, so a sample write touches only its own byte.
	for (genvar c = 0; c < CHANNELS; c++) begin : g_pix
		mfc_ram #(
			.WIDTH (8),
			.DEPTH (1 << PAW)
		) u_pix_ram (
			.clk   (clk),
			.we    (pix_ok && (int'(channel) == c)),
			.waddr (pix_waddr),
			.wdata (sample),
			.re    (mac_ctrl.issue),
			.raddr (pix_raddr),
			.rdata (pix_rdata[c])
		);
	end

	mfc_seq #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.MAX_FRAMES      (MAX_FRAMES),
		.MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.interior    (interior),
		.base_y      (row_e - pad_h),
		.base_x      (col_e - pad_w),
		.kw          (kw_sat),
		.kh          (kh_sat),
		.kd          (kd_sat),
		.mac_pending (mac_pending),
		.out_free    (out_free),
		.busy        (seq_busy),
		.mac_ctrl    (mac_ctrl),
		.coef_addr   (coef_raddr),
		.pix_addr    (pix_raddr),
		.load        (load),
		.pos_valid   (seq_pos_valid)
	);

	mfc_mac #(
		.MAX_FRAMES      (MAX_FRAMES),
		.MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.pix     (pix_rdata),
		.coef    (signed'(coef_rdata)),
		.cs      (cs_sat),
		.pending (mac_pending),
		.result  (mac_result)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			position_valid_q <= seq_pos_valid;
			result_q         <= seq_pos_valid ? mac_result : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign position_valid = position_valid_q;
	assign result_ch0     = result_q[0];
	assign result_ch1     = result_q[1];
	assign result_ch2     = result_q[2];
	assign results_zero   = (result_q == '0);

	`MFC_ASSERT_NEXT(a_compute_holds_input, clk, arst_n, start, in_stall)
	`MFC_ASSERT_IMP(a_idle_means_mac_empty, clk, arst_n, !in_stall, !mac_pending)
	`MFC_ASSERT_IMP(a_load_only_when_free, clk, arst_n, load, out_free)
	`MFC_ASSERT_IMP(a_border_gives_zero, clk, arst_n, out_valid && !position_valid, results_zero)

endmodule
